>>> rtl/cip_pkg.sv
// ----------------------------------------------------------------------------
// Checked integer power: shared package
// Word widths, operand types and the status codes of a result.
// ----------------------------------------------------------------------------
package cip_pkg;

  localparam int unsigned IO_W       = 64;
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned HALF_W     = (DATA_WIDTH + 1) / 2;
  localparam int unsigned PP_W       = 2 * HALF_W;

  typedef logic [DATA_WIDTH-1:0]   word_t;
  typedef logic [2*DATA_WIDTH-1:0] dword_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEG_EXP   = 2'd1,
    ST_ZERO_ZERO = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

endpackage

>>> rtl/checked_integer_power.sv
// ----------------------------------------------------------------------------
// Checked integer power
// Raises a signed base to a non-negative exponent by square-and-multiply and
// flags a negative exponent, zero to the zero, and overflow.
// ----------------------------------------------------------------------------
// One item is worked on at a time, and the input is ready only while the
// sequencer is idle. Special inputs (negative exponent, zero base, base of
// plus or minus one) skip the square-and-multiply loop. Otherwise each
// exponent bit takes sequencing plus a multiply for every square and every
// accumulate, all on one shared 32 by 32 bit multiplier whose four partial
// products are summed in a 128-bit register. A base of magnitude two or
// more exceeds the range after at most six squares. The input is ready
// again from the same cycle in which a result is offered. The finished
// result waits in an output register, so the next item can be taken before
// the previous result transfer.
module checked_integer_power (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cip_pkg::IO_W-1:0]   base_value_i,
  input  logic signed [cip_pkg::IO_W-1:0]   exponent_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cip_pkg::IO_W-1:0]   power_result_o,
  output logic [1:0]                        result_status_o
);
  import cip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_MUL,
    S_MCHK,
    S_ADV,
    S_DONE
  } state_e;

  typedef enum logic {
    OP_ACC,
    OP_SQR
  } mop_e;

  localparam word_t    LIM      = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t    ONE      = word_t'(1);
  localparam logic [2:0] CNT_LAST = 3'd4;

  state_e  state_q;
  mop_e    op_q;
  word_t   acc_q, sq_q, e_q, res_q, out_res_q;
  logic    neg_q;
  status_e stat_q, out_stat_q;
  logic    out_valid_q;
  logic [2:0]      cnt_q;
  logic [PP_W-1:0] pp_q;
  logic [1:0]      sh_q;
  logic            pv_q;
  dword_t          prod_q;

  word_t           b_w, e_w, mag_w, e_shr;
  logic [PP_W-1:0] opa, opb, pp_d;
  logic [HALF_W-1:0] pa, pb;
  dword_t          pp_ext;
  logic            prod_big;

  assign b_w   = base_value_i[DATA_WIDTH-1:0];
  assign e_w   = exponent_value_i[DATA_WIDTH-1:0];
  assign mag_w = b_w[DATA_WIDTH-1] ? (~b_w + ONE) : b_w;
  assign e_shr = e_q >> 1;

  assign opa  = PP_W'((op_q == OP_ACC) ? acc_q : sq_q);
  assign opb  = PP_W'(sq_q);
  assign pa   = cnt_q[0] ? opa[PP_W-1:HALF_W] : opa[HALF_W-1:0];
  assign pb   = cnt_q[1] ? opb[PP_W-1:HALF_W] : opb[HALF_W-1:0];
  assign pp_d = PP_W'(pa) * PP_W'(pb);

  assign pp_ext   = dword_t'(pp_q) << (sh_q * HALF_W);
  assign prod_big = prod_q > dword_t'(LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ACC;
      acc_q       <= '0;
      sq_q        <= '0;
      e_q         <= '0;
      res_q       <= '0;
      neg_q       <= 1'b0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_stat_q  <= ST_OK;
      cnt_q       <= '0;
      pp_q        <= '0;
      sh_q        <= '0;
      pv_q        <= 1'b0;
      prod_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            acc_q <= ONE;
            sq_q  <= mag_w;
            e_q   <= e_w;
            neg_q <= b_w[DATA_WIDTH-1] & e_w[0];
            res_q <= '0;
            if (e_w[DATA_WIDTH-1]) begin
              stat_q  <= ST_NEG_EXP;
              state_q <= S_DONE;
            end else if (b_w == '0) begin
              stat_q  <= (e_w == '0) ? ST_ZERO_ZERO : ST_OK;
              state_q <= S_DONE;
            end else if (mag_w == ONE) begin
              stat_q  <= ST_OK;
              res_q   <= (b_w[DATA_WIDTH-1] & e_w[0]) ? '1 : ONE;
              state_q <= S_DONE;
            end else begin
              state_q <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (e_q == '0) begin
            if (!neg_q && acc_q[DATA_WIDTH-1]) begin
              stat_q <= ST_OVERFLOW;
              res_q  <= '0;
            end else begin
              stat_q <= ST_OK;
              res_q  <= neg_q ? (~acc_q + ONE) : acc_q;
            end
            state_q <= S_DONE;
          end else if (e_q[0]) begin
            op_q    <= OP_ACC;
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            prod_q  <= '0;
            state_q <= S_MUL;
          end else begin
            state_q <= S_ADV;
          end
        end
        S_MUL: begin
          if (pv_q) begin
            prod_q <= prod_q + pp_ext;
          end
          pp_q  <= pp_d;
          sh_q  <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
          pv_q  <= (cnt_q != CNT_LAST);
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_MCHK;
          end
        end
        S_MCHK: begin
          if (prod_big) begin
            stat_q  <= ST_OVERFLOW;
            res_q   <= '0;
            state_q <= S_DONE;
          end else if (op_q == OP_ACC) begin
            acc_q   <= prod_q[DATA_WIDTH-1:0];
            state_q <= S_ADV;
          end else begin
            sq_q    <= prod_q[DATA_WIDTH-1:0];
            state_q <= S_LOOP;
          end
        end
        S_ADV: begin
          e_q <= e_shr;
          if (e_shr == '0) begin
            state_q <= S_LOOP;
          end else begin
            op_q    <= OP_SQR;
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            prod_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_res_q   <= res_q;
            out_stat_q  <= stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign power_result_o  = IO_W'($signed(out_res_q));
  assign result_status_o = out_stat_q;

endmodule

>>> rtl/cip_checker.sv
// ----------------------------------------------------------------------------
// Checked integer power: port checker
// Watches the ports of the top level and reports protocol or result slips.
// ----------------------------------------------------------------------------
module cip_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [cip_pkg::IO_W-1:0] power_result_o,
  input logic [1:0]                      result_status_o
);
  import cip_pkg::*;

  // A pending result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(power_result_o) && $stable(result_status_o))
    else $error("result changed before its transfer");

  // Any status other than ok carries a zero result.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_status_o != ST_OK) |-> power_result_o == '0)
    else $error("nonzero result with an error status");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an input transfer");

endmodule

bind checked_integer_power cip_checker u_cip_checker (.*);
